// File: rtl/egbw_pkg.sv
`timescale 1ns / 1ps

package egbw_pkg;

  // Request codes.
  localparam logic [1:0] OP_FIXED = 2'd0;
  localparam logic [1:0] OP_UE    = 2'd1;
  localparam logic [1:0] OP_SE    = 2'd2;
  localparam logic [1:0] OP_ALIGN = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UE_ONES = 2'd1;
  localparam logic [1:0] ERR_SE_MIN  = 2'd2;

  localparam logic [31:0] UE_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] SE_MIN      = 32'h8000_0000;
  localparam logic [6:0]  FIELD_MAX   = 7'd64;
  localparam logic [6:0]  BYTE_BITS   = 7'd8;
  localparam int          ACC_W       = 72;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] value;
    logic [6:0]  bit_count;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [6:0] code_length;
    logic [1:0] error;
    logic       last;
  } rsp_t;

  // Classified request: the code is left aligned, n_bits of it are valid.
  typedef struct packed {
    logic        align;
    logic [63:0] code;
    logic [6:0]  n_bits;
    logic [6:0]  code_length;
    logic [1:0]  error;
  } code_t;

endpackage

// File: rtl/egbw_front.sv
`timescale 1ns / 1ps

module egbw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  egbw_pkg::req_t req_word,
  output logic           push,
  input  logic           full,
  output egbw_pkg::code_t wdata
);

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [63:0] s1_word;
  logic [6:0]  s1_n;
  logic [1:0]  s1_err;

  logic [63:0] s1_word_next;
  logic [6:0]  s1_n_next;
  logic [1:0]  s1_err_next;
  logic [31:0] v32;
  logic [31:0] se_mapped;

  logic [31:0] ue_x;
  logic [4:0]  ue_msb;
  logic [5:0]  ue_shift;
  logic [63:0] ue_code;
  logic [6:0]  ue_n;

  assign req_stall = s1_valid && full;
  assign push      = s1_valid && !full;

  // First stage: map se onto ue, detect the error values and zero fixed widths over FIELD_MAX.
  always_comb begin
    v32 = req_word.value[31:0];
    if (v32[31] || (v32 == 32'd0)) begin
      se_mapped = (32'd0 - v32) << 1;
    end else begin
      se_mapped = (v32 << 1) - 32'd1;
    end
    s1_word_next = 64'd0;
    s1_n_next    = 7'd0;
    s1_err_next  = egbw_pkg::ERR_NONE;
    case (req_word.operation)
      egbw_pkg::OP_FIXED: begin
        s1_word_next = req_word.value;
        if (req_word.bit_count <= egbw_pkg::FIELD_MAX) begin
          s1_n_next = req_word.bit_count;
        end
      end
      egbw_pkg::OP_UE: begin
        s1_word_next = {32'd0, v32};
        if (v32 == egbw_pkg::UE_ALL_ONES) begin
          s1_err_next = egbw_pkg::ERR_UE_ONES;
        end
      end
      egbw_pkg::OP_SE: begin
        s1_word_next = {32'd0, se_mapped};
        if (v32 == egbw_pkg::SE_MIN) begin
          s1_err_next = egbw_pkg::ERR_SE_MIN;
        end
      end
      default: begin
        s1_word_next = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      s1_op   <= req_word.operation;
      s1_word <= s1_word_next;
      s1_n    <= s1_n_next;
      s1_err  <= s1_err_next;
    end
  end

  // Second stage: build the Exp-Golomb code, left align every code and flag align requests.
  always_comb begin
    ue_x   = s1_word[31:0] + 32'd1;
    ue_msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (ue_x[i]) begin
        ue_msb = 5'(i);
      end
    end
    ue_shift = 6'd63 - {ue_msb, 1'b0};
    ue_code  = {32'd0, ue_x} << ue_shift;
    ue_n     = {1'b0, ue_msb, 1'b0} + 7'd1;

    wdata.align       = 1'b0;
    wdata.code        = 64'd0;
    wdata.n_bits      = 7'd0;
    wdata.code_length = 7'd0;
    wdata.error       = s1_err;
    case (s1_op)
      egbw_pkg::OP_FIXED: begin
        wdata.code        = s1_word << (egbw_pkg::FIELD_MAX - s1_n);
        wdata.n_bits      = s1_n;
        wdata.code_length = s1_n;
      end
      egbw_pkg::OP_UE, egbw_pkg::OP_SE: begin
        if (s1_err == egbw_pkg::ERR_NONE) begin
          wdata.code        = ue_code;
          wdata.n_bits      = ue_n;
          wdata.code_length = ue_n;
        end
      end
      default: begin
        wdata.align = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/egbw_queue.sv
`timescale 1ns / 1ps

module egbw_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  egbw_pkg::code_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output egbw_pkg::code_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  egbw_pkg::code_t entries [DEPTH];
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= wdata;
    end
  end

endmodule

// File: rtl/egbw_back.sv
`timescale 1ns / 1ps

module egbw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  egbw_pkg::code_t rdata,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output egbw_pkg::rsp_t  rsp_word
);

  localparam int AW = egbw_pkg::ACC_W;

  // Pending bits of the unfinished byte are kept left aligned.
  logic [6:0]    pl;
  logic [2:0]    pc;
  logic          active;
  logic [AW-1:0] cur_acc;
  logic [6:0]    cur_rem;
  logic [6:0]    cur_len;
  logic [1:0]    cur_err;

  logic [6:0]    load_n;
  logic [AW-1:0] load_acc;
  logic [6:0]    load_rem;
  logic [AW-1:0] src_acc;
  logic [6:0]    src_rem;
  logic [6:0]    src_len;
  logic [1:0]    src_err;
  logic [6:0]    rem_after;
  logic          out_free;
  logic          take;
  logic          has_byte;
  logic          final_byte;
  egbw_pkg::rsp_t rsp_next;

  always_comb begin
    if (rdata.align) begin
      load_n = (pc == 3'd0) ? 7'd0 : egbw_pkg::BYTE_BITS - {4'd0, pc};
    end else begin
      load_n = rdata.n_bits;
    end
    load_acc = {pl, 65'd0} | ({rdata.code, 8'd0} >> pc);
    load_rem = {4'd0, pc} + load_n;

    src_acc = active ? cur_acc : load_acc;
    src_rem = active ? cur_rem : load_rem;
    src_len = active ? cur_len : rdata.code_length;
    src_err = active ? cur_err : rdata.error;

    out_free   = !rsp_valid || !rsp_stall;
    take       = out_free && (active || !empty);
    pop        = out_free && !active && !empty;
    has_byte   = (src_rem >= egbw_pkg::BYTE_BITS);
    final_byte = (src_rem < (egbw_pkg::BYTE_BITS << 1));
    rem_after  = src_rem - egbw_pkg::BYTE_BITS;

    rsp_next.out_byte    = has_byte ? src_acc[AW-1 -: 8] : 8'd0;
    rsp_next.byte_valid  = has_byte;
    rsp_next.last        = !has_byte || final_byte;
    rsp_next.code_length = rsp_next.last ? src_len : 7'd0;
    rsp_next.error       = rsp_next.last ? src_err : egbw_pkg::ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      active    <= 1'b0;
      pl        <= 7'd0;
      pc        <= 3'd0;
    end else if (out_free) begin
      rsp_valid <= take;
      if (take) begin
        if (!has_byte) begin
          // Nothing completes a byte: the bits all stay pending.
          active <= 1'b0;
          pl     <= src_acc[AW-1 -: 7];
          pc     <= src_rem[2:0];
        end else if (final_byte) begin
          active <= 1'b0;
          pl     <= src_acc[AW-9 -: 7];
          pc     <= rem_after[2:0];
        end else begin
          active <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_word <= rsp_next;
      cur_acc  <= src_acc << 8;
      cur_rem  <= rem_after;
      cur_len  <= src_len;
      cur_err  <= src_err;
    end
  end

`ifndef SYNTHESIS
  a_active_has_byte: assert property (@(posedge clk) disable iff (rst)
    active |-> (cur_rem >= egbw_pkg::BYTE_BITS))
    else $error("busy request has less than a byte left");

  a_partial_aligned: assert property (@(posedge clk) disable iff (rst)
    (pl << pc) == 7'd0)
    else $error("pending bits are not left aligned");

  a_empty_word_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_word.byte_valid) |-> rsp_word.last)
    else $error("word without a byte is not the last of its request");

  a_meta_on_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_word.last) |->
      (rsp_word.code_length == 7'd0 && rsp_word.error == egbw_pkg::ERR_NONE))
    else $error("length or error on a word that is not the last");
`endif

endmodule

// File: rtl/exp_golomb_bit_writer_top.sv
`timescale 1ns / 1ps

// The first word of a request passes the front stage register, the queue and the output register.
// Throughput: one word per cycle while words are queued and rsp_stall is low; a request yields
// one to eight words, set by the byte serializer in the back end.
// Reset clears the pending partial byte, the queue and all valid flags.

module exp_golomb_bit_writer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  egbw_pkg::req_t req_word,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output egbw_pkg::rsp_t rsp_word
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  egbw_pkg::code_t q_wdata;
  egbw_pkg::code_t q_rdata;

  egbw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .push      (q_push),
    .full      (q_full),
    .wdata     (q_wdata)
  );

  egbw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  egbw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .rdata     (q_rdata),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_TAIL     = 16;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  egbw_pkg::req_t req_word = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  egbw_pkg::rsp_t rsp_word;

  exp_golomb_bit_writer_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_word (req_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word (rsp_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit packer state mirrored by the predictor.
  logic [6:0]     pend_bits = '0;
  logic [2:0]     pend_cnt  = '0;
  logic [7:0]     new_bytes[$];
  egbw_pkg::rsp_t expected_words[$];

  int   fail_count = 0;
  int   word_count = 0;
  bit   quiet = 1'b0;
  int   hold_start = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("word %0d: %s is %0h, should be %0h", word_count, what, got, want);
    fail_count++;
  endtask

  function automatic int idle_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic egbw_pkg::req_t make_req(input logic [1:0] op, input logic [63:0] value,
                                              input logic [6:0] count);
    egbw_pkg::req_t r;
    r.operation = op;
    r.value     = value;
    r.bit_count = count;
    return r;
  endfunction

  // Appends the low n bits of v to the stream, most significant first.
  task automatic emit_bits(input logic [63:0] v, input int n);
    logic [7:0] acc;
    for (int i = n; i > 0; i--) begin
      acc = {pend_bits, v[i-1]};
      if ({4'd0, pend_cnt} == egbw_pkg::BYTE_BITS - 7'd1) begin
        new_bytes.push_back(acc);
        pend_bits = '0;
        pend_cnt  = '0;
      end else begin
        pend_bits = acc[6:0];
        pend_cnt  = pend_cnt + 3'd1;
      end
    end
  endtask

  task automatic emit_ue(input logic [31:0] v, output logic [6:0] len);
    logic [32:0] x;
    int          lz;
    x  = {1'b0, v} + 33'd1;
    lz = 0;
    for (int i = 0; i < 33; i++)
      if (x[i]) lz = i;
    emit_bits(64'd0, lz);
    emit_bits({31'd0, x}, lz + 1);
    len = 7'(2 * lz + 1);
  endtask

  task automatic predict_words(input egbw_pkg::req_t r);
    logic [31:0]    v32;
    logic [31:0]    mapped;
    logic [6:0]     len;
    logic [1:0]     err;
    logic [7:0]     padded;
    egbw_pkg::rsp_t w;
    bit             fin;
    v32 = r.value[31:0];
    len = '0;
    err = egbw_pkg::ERR_NONE;
    new_bytes.delete();
    case (r.operation)
      egbw_pkg::OP_FIXED: begin
        if (r.bit_count <= egbw_pkg::FIELD_MAX) begin
          emit_bits(r.value, r.bit_count);
          len = r.bit_count;
        end
      end
      egbw_pkg::OP_UE: begin
        if (v32 == egbw_pkg::UE_ALL_ONES) err = egbw_pkg::ERR_UE_ONES;
        else emit_ue(v32, len);
      end
      egbw_pkg::OP_SE: begin
        if (v32 == egbw_pkg::SE_MIN) begin
          err = egbw_pkg::ERR_SE_MIN;
        end else begin
          // Zero and negative values take the even codes.
          if (v32[31] || v32 == 32'd0) mapped = (32'd0 - v32) << 1;
          else mapped = (v32 << 1) - 32'd1;
          emit_ue(mapped, len);
        end
      end
      default: begin
        if (pend_cnt != 3'd0) begin
          padded = {1'b0, pend_bits};
          padded = padded << (egbw_pkg::BYTE_BITS - {4'd0, pend_cnt});
          new_bytes.push_back(padded);
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
    endcase
    if (new_bytes.size() == 0) begin
      w.out_byte    = 8'd0;
      w.byte_valid  = 1'b0;
      w.code_length = len;
      w.error       = err;
      w.last        = 1'b1;
      expected_words.push_back(w);
    end else begin
      foreach (new_bytes[k]) begin
        fin           = (k == new_bytes.size() - 1);
        w.out_byte    = new_bytes[k];
        w.byte_valid  = 1'b1;
        w.code_length = fin ? len : 7'd0;
        w.error       = fin ? err : egbw_pkg::ERR_NONE;
        w.last        = fin;
        expected_words.push_back(w);
      end
    end
  endtask

  // Offers one request word and returns at the edge that accepts it, with valid
  // still high so that a zero gap keeps the channel busy.
  task automatic send_word(input egbw_pkg::req_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_words(r);
    req_valid <= 1'b1;
    req_word  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic egbw_pkg::req_t random_request();
    egbw_pkg::req_t r;
    int   pick;
    int   sel;
    r.value     = {$urandom, $urandom};
    r.bit_count = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (pick < 35) begin
      r.operation = egbw_pkg::OP_FIXED;
      if (sel < 80) r.bit_count = 7'($urandom_range(0, 24));
      else if (sel < 95) r.bit_count = 7'($urandom_range(25, 64));
      else r.bit_count = 7'($urandom_range(65, 127));
    end else if (pick < 60) begin
      r.operation = egbw_pkg::OP_UE;
      if (sel < 50) r.value[31:0] = $urandom_range(0, 300);
      else if (sel < 60) r.value[31:0] = egbw_pkg::UE_ALL_ONES;
      else if (sel < 65) r.value[31:0] = egbw_pkg::UE_ALL_ONES - 32'd1;
    end else if (pick < 85) begin
      r.operation = egbw_pkg::OP_SE;
      if (sel < 50) r.value[31:0] = 32'($urandom_range(0, 600)) - 32'd300;
      else if (sel < 58) r.value[31:0] = egbw_pkg::SE_MIN;
      else if (sel < 62) r.value[31:0] = egbw_pkg::SE_MIN + 32'd1;
    end else begin
      r.operation = egbw_pkg::OP_ALIGN;
    end
    return r;
  endfunction

  egbw_pkg::rsp_t want_word;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(rsp_word), 64'd0);
      end else begin
        want_word = expected_words.pop_front();
        if (rsp_word.out_byte !== want_word.out_byte)
          report_mismatch("out_byte", 64'(rsp_word.out_byte), 64'(want_word.out_byte));
        if (rsp_word.byte_valid !== want_word.byte_valid)
          report_mismatch("byte_valid", 64'(rsp_word.byte_valid),
                          64'(want_word.byte_valid));
        if (rsp_word.code_length !== want_word.code_length)
          report_mismatch("code_length", 64'(rsp_word.code_length),
                          64'(want_word.code_length));
        if (rsp_word.error !== want_word.error)
          report_mismatch("error", 64'(rsp_word.error), 64'(want_word.error));
        if (rsp_word.last !== want_word.last)
          report_mismatch("last", 64'(rsp_word.last), 64'(want_word.last));
      end
      word_count++;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int run_left = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_start) begin
      hold_seen <= hold_start;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (run_left > 0) begin
      run_left  <= run_left - 1;
      rsp_stall <= 1'b0;
    end else begin
      run_left   <= $urandom_range(0, 20);
      stall_left <= idle_gap();
      rsp_stall  <= 1'b0;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_fixed_fields();
    send_word(make_req(egbw_pkg::OP_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'h0000_0000_0000_0001, 7'd1));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'hFFFF_FFFF_FFFF_FF5A, 7'd8));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'hA5A5_5A5A_0F0F_F0F0, 7'd64));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'h1234_5678_9ABC_DEF0, 7'd65));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'h0000_0000_0000_0000, 7'd63));
  endtask

  task automatic test_ue_codes();
    send_word(make_req(egbw_pkg::OP_UE, 64'd0, 7'd0));
    send_word(make_req(egbw_pkg::OP_UE, 64'd1, 7'd127));
    send_word(make_req(egbw_pkg::OP_UE, 64'd2, 7'd0));
    send_word(make_req(egbw_pkg::OP_UE, 64'h0000_0000_FFFF_FFFE, 7'd0));
    send_word(make_req(egbw_pkg::OP_UE, 64'h0000_0000_FFFF_FFFF, 7'd0));
    send_word(make_req(egbw_pkg::OP_UE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    send_word(make_req(egbw_pkg::OP_UE, 64'hDEAD_BEEF_0000_0007, 7'd5));
  endtask

  task automatic test_se_codes();
    send_word(make_req(egbw_pkg::OP_SE, 64'd0, 7'd0));
    send_word(make_req(egbw_pkg::OP_SE, 64'd1, 7'd0));
    send_word(make_req(egbw_pkg::OP_SE, 64'h0000_0000_FFFF_FFFF, 7'd0));
    send_word(make_req(egbw_pkg::OP_SE, 64'h0000_0000_7FFF_FFFF, 7'd0));
    send_word(make_req(egbw_pkg::OP_SE, 64'h0000_0000_8000_0001, 7'd0));
    send_word(make_req(egbw_pkg::OP_SE, 64'hFFFF_FFFF_8000_0000, 7'd0));
  endtask

  task automatic test_byte_alignment();
    // The first align may or may not find pending bits; the second never does.
    send_word(make_req(egbw_pkg::OP_ALIGN, 64'd0, 7'd0));
    send_word(make_req(egbw_pkg::OP_ALIGN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'h5, 7'd3));
    send_word(make_req(egbw_pkg::OP_ALIGN, 64'd0, 7'd0));
    send_word(make_req(egbw_pkg::OP_FIXED, 64'h7F, 7'd7));
    send_word(make_req(egbw_pkg::OP_ALIGN, 64'd0, 7'd0));
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (40) send_word(random_request());
    quiet = 1'b0;
  endtask

  task automatic test_output_hold_off();
    // The receiver stops for a long stretch while requests keep coming, so the
    // queue fills and the request side stalls.
    hold_start <= hold_start + 1;
    repeat (30) send_word(random_request());
  endtask

  task automatic test_drained_pause();
    wait_drained();
    repeat (10) send_word(random_request());
  endtask

  task automatic test_random_mix();
    repeat (250) send_word(random_request());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_fixed_fields();
    test_ue_codes();
    test_se_codes();
    test_byte_alignment();
    test_back_to_back();
    test_output_hold_off();
    test_drained_pause();
    test_random_mix();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/egbw_pkg.sv
rtl/egbw_front.sv
rtl/egbw_queue.sv
rtl/egbw_back.sv
rtl/exp_golomb_bit_writer_top.sv
tb/sv/testbench.sv
